FILE: rtl/csof_pkg.sv
`default_nettype none
package csof_pkg;
    localparam int unsigned ScaleWidth = 8;
    localparam logic [ScaleWidth-1:0] ScaleReset = 8'd32;
    localparam int unsigned CoordWidth = 16;
endpackage
`default_nettype wire

FILE: rtl/centroid_sigma_outlier_filter.sv
`default_nettype none
// Channel    Dir  Contents
// s_axis     in   tdata = point_x, point_y; tlast = last_point
// m_axis     out  tdata = inlier_x, inlier_y; tlast = last_inlier; tuser = overflowed
// cfg        in   i_cfg_we / i_cfg_wdata = sigma_scale
// A non-last point is accepted while loading. The last point starts a sequenced evaluation
// through one shared restoring divider and one shared square root unit, both one bit per
// cycle. It runs the centroid divides, the distances, then the mean, the variance, the
// variance divide and root, then the emit pass over the point memory, which output stalls
// can hold. Reset is synchronous and active low; the input is not ready during evaluation.
module centroid_sigma_outlier_filter #(
    parameter int unsigned MAX_POINTS  = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [31:0]                   s_axis_tdata,   // point_x [15:0], point_y [31:16]
    input  wire                          s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [31:0]                  m_axis_tdata,   // inlier_x [15:0], inlier_y [31:16]
    output logic                         m_axis_tlast,
    output logic                         m_axis_tuser,   // overflowed [0]
    input  wire                          i_cfg_we,
    input  wire [csof_pkg::ScaleWidth-1:0] i_cfg_wdata
);
    import csof_pkg::*;

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned SW = CoordWidth + CW;           // sums of coordinates
    localparam int unsigned DW = CoordWidth + 1;            // distance
    localparam int unsigned RW = 2 * CoordWidth + 2;        // radicand
    localparam int unsigned QW = 2 * DW + CW;               // sum of squares
    localparam int unsigned NW = (QW > SW + 1) ? QW : SW + 1; // divider width
    localparam int unsigned TW = (RW > QW) ? RW : QW;       // sqrt input width
    localparam int unsigned HW = (TW + 1) / 2;              // sqrt result width
    localparam int unsigned NB = 2 * HW;
    localparam int unsigned LW = DW + 4 + ScaleWidth + 1;   // limit width
    localparam int unsigned PW = 2 * CoordWidth;
    localparam logic [AW-1:0] LastAddr = AW'(MAX_POINTS - 1);

    typedef enum logic [4:0] {
        S_LOAD, S_DIVX, S_DIVY, S_DRD, S_DWAIT, S_DSQ, S_DSQRT, S_DWR, S_MEAN,
        S_VRD, S_VWAIT, S_VACC, S_VDIV, S_VSQRT, S_LIMIT, S_ORD, S_OWAIT, S_OCHK,
        S_OSEND, S_DONE
    } t_state;

    t_state r_state;
    logic [ScaleWidth-1:0] r_scale;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_sum_x, r_sum_y;
    logic r_ovf;
    logic [AW-1:0] r_idx;
    logic [CoordWidth-1:0] r_cx, r_cy;
    logic [SW+DW-1:0] r_sum_d;
    logic [DW-1:0] r_mean;
    logic [QW-1:0] r_sum_sq;
    logic [LW-1:0] r_limit;
    logic [RW-1:0] r_rad;
    logic [DW-1:0] r_dist;
    logic [PW-1:0] r_pt;
    logic r_have;          // a kept point waits in the held register
    logic [PW-1:0] r_held;

    // Shared divider: quotient of r_dnum by r_count, one bit per cycle.
    logic [NW-1:0] r_dnum, r_quo;
    logic [NW:0] r_rem;
    logic [$clog2(NW+1)-1:0] r_dcnt;
    // Shared square root, two radicand bits per cycle.
    logic [NB-1:0] r_sv;
    logic [HW+1:0] r_srem;
    logic [HW-1:0] r_sroot;
    logic [$clog2(HW+1)-1:0] r_scnt;

    logic [PW-1:0] w_prd;
    logic [DW-1:0] w_drd;
    logic w_pwe, w_dwe;
    logic [AW-1:0] w_pwa, w_ra;
    logic [NW:0] w_rsh;
    logic [HW+1:0] w_sr, w_st;

    assign w_pwe = (r_state == S_LOAD) && s_axis_tvalid && s_axis_tready
                   && (r_count < CW'(MAX_POINTS));
    assign w_pwa = r_count[AW-1:0];
    assign w_dwe = (r_state == S_DWR);
    assign w_ra = r_idx;

    csof_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (
        .i_clk(i_clk), .i_we(w_pwe), .i_waddr(w_pwa),
        .i_wdata({s_axis_tdata[16 +: CoordWidth], s_axis_tdata[0 +: CoordWidth]}),
        .i_raddr(w_ra), .o_rdata(w_prd)
    );
    csof_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_dst (
        .i_clk(i_clk), .i_we(w_dwe), .i_waddr(r_idx), .i_wdata(r_dist),
        .i_raddr(w_ra), .o_rdata(w_drd)
    );

    assign w_rsh = {r_rem[NW-1:0], r_dnum[NW-1]};
    assign w_sr = {r_srem[HW-1:0], r_sv[NB-1 -: 2]};
    assign w_st = {r_sroot, 2'b01};

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = (r_state == S_OSEND) || (r_state == S_DONE && r_have);

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[0 +: CoordWidth] = r_held[0 +: CoordWidth];
        m_axis_tdata[16 +: CoordWidth] = r_held[CoordWidth +: CoordWidth];
    end
    assign m_axis_tlast = (r_state == S_DONE);
    assign m_axis_tuser = r_ovf;

    function automatic logic [CoordWidth-1:0] f_absd(input logic [CoordWidth-1:0] a,
                                                     input logic [CoordWidth-1:0] b);
        f_absd = (a >= b) ? (a - b) : (b - a);
    endfunction

    // Start the divider on a numerator.
    task automatic t_div_start(input logic [NW-1:0] num);
        r_dnum <= num;
        r_rem <= '0;
        r_quo <= '0;
        r_dcnt <= '0;
    endtask

    task automatic t_sqrt_start(input logic [TW-1:0] v);
        r_sv <= NB'(v);
        r_srem <= '0;
        r_sroot <= '0;
        r_scnt <= '0;
    endtask

    logic [CoordWidth-1:0] w_dx, w_dy;
    logic [DW-1:0] w_e;
    assign w_dx = f_absd(w_prd[0 +: CoordWidth], r_cx);
    assign w_dy = f_absd(w_prd[CoordWidth +: CoordWidth], r_cy);
    assign w_e = (w_drd >= r_mean) ? (w_drd - r_mean) : (r_mean - w_drd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_scale <= ScaleReset;
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_ovf <= 1'b0;
            r_have <= 1'b0;
            r_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            case (r_state)
                S_LOAD: begin
                    if (s_axis_tvalid) begin
                        if (r_count < CW'(MAX_POINTS)) begin
                            r_count <= r_count + 1'b1;
                            r_sum_x <= r_sum_x + SW'(s_axis_tdata[0 +: CoordWidth]);
                            r_sum_y <= r_sum_y + SW'(s_axis_tdata[16 +: CoordWidth]);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_state <= S_DIVX;
                            if (r_count < CW'(MAX_POINTS)) begin
                                t_div_start(NW'(r_sum_x + SW'(s_axis_tdata[0 +: CoordWidth])
                                    + SW'((r_count + 1'b1) >> 1)));
                            end else begin
                                t_div_start(NW'(r_sum_x + SW'(r_count >> 1)));
                            end
                        end
                    end
                end
                S_DIVX, S_DIVY, S_MEAN, S_VDIV: begin
                    if (r_dcnt != ($clog2(NW+1))'(NW)) begin
                        r_dcnt <= r_dcnt + 1'b1;
                        r_dnum <= r_dnum << 1;
                        if (w_rsh >= (NW+1)'(r_count)) begin
                            r_rem <= w_rsh - (NW+1)'(r_count);
                            r_quo <= {r_quo[NW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_quo <= {r_quo[NW-2:0], 1'b0};
                        end
                    end else begin
                        case (r_state)
                            S_DIVX: begin
                                r_cx <= r_quo[CoordWidth-1:0];
                                t_div_start(NW'(r_sum_y + SW'(r_count >> 1)));
                                r_state <= S_DIVY;
                            end
                            S_DIVY: begin
                                r_cy <= r_quo[CoordWidth-1:0];
                                r_idx <= '0;
                                r_sum_d <= '0;
                                r_state <= S_DRD;
                            end
                            S_MEAN: begin
                                r_mean <= r_quo[DW-1:0];
                                r_idx <= '0;
                                r_sum_sq <= '0;
                                r_state <= S_VRD;
                            end
                            default: begin
                                t_sqrt_start(TW'(r_quo));
                                r_state <= S_VSQRT;
                            end
                        endcase
                    end
                end
                S_DRD: r_state <= S_DWAIT;
                S_DWAIT: begin
                    r_rad <= RW'(w_dx * w_dx);
                    r_pt <= PW'(w_dy);
                    r_state <= S_DSQ;
                end
                S_DSQ: begin
                    t_sqrt_start(TW'(r_rad + RW'(r_pt[CoordWidth-1:0] * r_pt[CoordWidth-1:0])));
                    r_state <= S_DSQRT;
                end
                S_DSQRT, S_VSQRT: begin
                    if (r_scnt != ($clog2(HW+1))'(HW)) begin
                        r_scnt <= r_scnt + 1'b1;
                        r_sv <= r_sv << 2;
                        if (w_sr >= w_st) begin
                            r_srem <= w_sr - w_st;
                            r_sroot <= {r_sroot[HW-2:0], 1'b1};
                        end else begin
                            r_srem <= w_sr;
                            r_sroot <= {r_sroot[HW-2:0], 1'b0};
                        end
                    end else if (r_state == S_DSQRT) begin
                        r_dist <= r_sroot[DW-1:0];
                        r_sum_d <= r_sum_d + (SW+DW)'(r_sroot[DW-1:0]);
                        r_state <= S_DWR;
                    end else begin
                        r_limit <= LW'({r_mean, 4'b0000}) + LW'(r_scale * r_sroot[DW-1:0]);
                        r_state <= S_LIMIT;
                    end
                end
                S_DWR: begin
                    if (CW'(r_idx) + 1'b1 == r_count || r_idx == LastAddr) begin
                        t_div_start(NW'(r_sum_d + (SW+DW)'(r_count >> 1)));
                        r_state <= S_MEAN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_VRD: r_state <= S_VWAIT;
                S_VWAIT: begin
                    r_rad <= RW'(w_e * w_e);
                    r_state <= S_VACC;
                end
                S_VACC: begin
                    r_sum_sq <= r_sum_sq + QW'(r_rad);
                    if (CW'(r_idx) + 1'b1 == r_count || r_idx == LastAddr) begin
                        t_div_start(NW'(r_sum_sq + QW'(r_rad)));
                        r_state <= S_VDIV;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_VRD;
                    end
                end
                S_LIMIT: begin
                    r_idx <= '0;
                    r_have <= 1'b0;
                    r_state <= S_ORD;
                end
                S_ORD: r_state <= S_OWAIT;
                S_OWAIT: r_state <= S_OCHK;
                S_OCHK: begin
                    if (LW'({w_drd, 4'b0000}) <= r_limit) begin
                        if (r_have) begin
                            r_state <= S_OSEND;
                        end else begin
                            r_have <= 1'b1;
                            r_held <= w_prd;
                            r_state <= (CW'(r_idx) + 1'b1 == r_count || r_idx == LastAddr)
                                       ? S_DONE : S_ORD;
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_state <= (CW'(r_idx) + 1'b1 == r_count || r_idx == LastAddr)
                                   ? S_DONE : S_ORD;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OSEND: begin
                    if (m_axis_tready) begin
                        r_held <= w_prd;
                        r_state <= (CW'(r_idx) + 1'b1 == r_count || r_idx == LastAddr)
                                   ? S_DONE : S_ORD;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_have || m_axis_tready) begin
                        r_have <= 1'b0;
                        r_count <= '0;
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                        r_ovf <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/csof_ram.sv
`default_nettype none
module csof_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
